// ===== sv/hcc_pkg.sv =====
// Shared types, constants and index helpers for the HChaCha20 subkey derivation core.
package hcc_pkg;

  localparam int unsigned HCC_DOUBLE_ROUNDS = 10;
  localparam int unsigned HCC_STEPS_PER_DR  = 8;
  localparam int unsigned HCC_WORDS         = 16;

  typedef logic [31:0] word_t;
  typedef logic [HCC_WORDS-1:0][31:0] state_t;

  typedef struct packed {
    logic [63:0] subkey_q3;
    logic [63:0] subkey_q2;
    logic [63:0] subkey_q1;
    logic [63:0] subkey_q0;
  } subkey_t;

  // "expand 32-byte k", word 0 in the low slot
  localparam logic [3:0][31:0] HCC_SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // Rotation applied by each of the four steps of a quarter-round
  function automatic int unsigned hcc_rot(input int unsigned step);
    int unsigned amt;
    case (step)
      0:       amt = 16;
      1:       amt = 12;
      2:       amt = 8;
      default: amt = 7;
    endcase
    return amt;
  endfunction

  // Word index of row 'row' (a=0, b=1, c=2, d=3) for quarter-round 'q';
  // the diagonal pass shifts row r by r columns.
  function automatic logic [3:0] hcc_idx(input logic diag, input int unsigned q,
                                         input int unsigned row);
    int unsigned col;
    col = (q + (diag ? row : 0)) % 4;
    return 4'(row * 4 + col);
  endfunction

endpackage

// ===== sv/hcc_key_if.sv =====
// Input channel: key and nonce lanes with valid/ready handshake.
interface hcc_key_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_lo0;
  logic [63:0] key_lo1;
  logic [63:0] key_hi0;
  logic [63:0] key_hi1;
  logic [63:0] nonce_lo;
  logic [63:0] nonce_hi;

  modport source (
    output valid, key_lo0, key_lo1, key_hi0, key_hi1, nonce_lo, nonce_hi,
    input  ready
  );
  modport sink (
    input  valid, key_lo0, key_lo1, key_hi0, key_hi1, nonce_lo, nonce_hi,
    output ready
  );
endinterface

// ===== sv/hcc_subkey_if.sv =====
// Output channel: derived subkey lanes with valid/ready handshake.
interface hcc_subkey_if;
  logic        valid;
  logic        ready;
  logic [63:0] subkey_q0;
  logic [63:0] subkey_q1;
  logic [63:0] subkey_q2;
  logic [63:0] subkey_q3;

  modport source (
    output valid, subkey_q0, subkey_q1, subkey_q2, subkey_q3,
    input  ready
  );
  modport sink (
    input  valid, subkey_q0, subkey_q1, subkey_q2, subkey_q3,
    output ready
  );
endinterface

// ===== sv/hcc_round_cell.sv =====
// One quarter-round step across all four quarter-rounds: x += y; z = rotl(z ^ x).
module hcc_round_cell import hcc_pkg::*; #(
  parameter int unsigned STEP = 0,
  parameter bit          DIAG = 1'b0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  state_t state_i,
  output logic   valid_o,
  output state_t state_o
);

  localparam int unsigned ROT   = hcc_rot(STEP);
  localparam int unsigned ROW_X = (STEP % 2 == 0) ? 0 : 2;
  localparam int unsigned ROW_Y = (STEP % 2 == 0) ? 1 : 3;
  localparam int unsigned ROW_Z = (STEP % 2 == 0) ? 3 : 1;

  logic   valid_q;
  state_t state_d, state_q;

  always_comb begin
    word_t      sum_w;
    word_t      mix_w;
    logic [3:0] xi, yi, zi;
    state_d = state_i;
    for (int unsigned q = 0; q < 4; q++) begin
      xi    = hcc_idx(DIAG, q, ROW_X);
      yi    = hcc_idx(DIAG, q, ROW_Y);
      zi    = hcc_idx(DIAG, q, ROW_Z);
      sum_w = state_i[xi] + state_i[yi];
      mix_w = state_i[zi] ^ sum_w;
      state_d[xi] = sum_w;
      state_d[zi] = (mix_w << ROT) | (mix_w >> (32 - ROT));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ===== sv/hcc_out_buf.sv =====
// Two-entry output register with skid slot; ready comes from flops only.
module hcc_out_buf import hcc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  subkey_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output subkey_t data_o
);

  logic    head_v_q, skid_v_q;
  subkey_t head_q, skid_q;
  logic    push, pop;

  assign ready_o = ~skid_v_q;
  assign push    = valid_i & ready_o;
  assign pop     = head_v_q & ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (pop) begin
      if (skid_v_q) begin
        skid_v_q <= 1'b0;
      end else begin
        head_v_q <= push;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_v_q <= 1'b1;
      end else begin
        head_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_v_q) begin
        head_q <= skid_q;
      end else if (push) begin
        head_q <= data_i;
      end
    end else if (push) begin
      if (head_v_q) begin
        skid_q <= data_i;
      end else begin
        head_q <= data_i;
      end
    end
  end

  assign valid_o = head_v_q;
  assign data_o  = head_q;

endmodule

// ===== sv/hchacha20_subkey_derive.sv =====
// HChaCha20 subkey derivation core, ten double rounds by default.
// One key/nonce beat per cycle unless stalled; the chain holds up to 8*DOUBLE_ROUNDS beats.
// The chain of quarter-round step cells sets the latency, one registered add/xor/rotate each.
// Backpressure: the chain advances while the output skid slot is empty.
// Reset (rst_ni low, asynchronous) clears all valid flags; data registers are not reset.
module hchacha20_subkey_derive import hcc_pkg::*; #(
  parameter int unsigned DOUBLE_ROUNDS = HCC_DOUBLE_ROUNDS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  hcc_key_if.sink       key_i,
  hcc_subkey_if.source  subkey_o
);

  // Eight step cells per double round: four column steps, then four diagonal steps.
  localparam int unsigned NUM_CELLS = DOUBLE_ROUNDS * HCC_STEPS_PER_DR;

  logic [NUM_CELLS:0] chain_v;
  state_t             chain_st [NUM_CELLS+1];
  logic               pipe_en;
  subkey_t            result, buf_data;

  // Build the initial matrix: constants, key words, nonce words (low half first).
  always_comb begin
    chain_st[0]     = '0;
    chain_st[0][0]  = HCC_SIGMA[0];
    chain_st[0][1]  = HCC_SIGMA[1];
    chain_st[0][2]  = HCC_SIGMA[2];
    chain_st[0][3]  = HCC_SIGMA[3];
    chain_st[0][4]  = key_i.key_lo0[31:0];
    chain_st[0][5]  = key_i.key_lo0[63:32];
    chain_st[0][6]  = key_i.key_lo1[31:0];
    chain_st[0][7]  = key_i.key_lo1[63:32];
    chain_st[0][8]  = key_i.key_hi0[31:0];
    chain_st[0][9]  = key_i.key_hi0[63:32];
    chain_st[0][10] = key_i.key_hi1[31:0];
    chain_st[0][11] = key_i.key_hi1[63:32];
    chain_st[0][12] = key_i.nonce_lo[31:0];
    chain_st[0][13] = key_i.nonce_lo[63:32];
    chain_st[0][14] = key_i.nonce_hi[31:0];
    chain_st[0][15] = key_i.nonce_hi[63:32];
  end

  // Accept a beat whenever the chain moves; bubbles travel along as invalid slots.
  assign chain_v[0]  = key_i.valid;
  assign key_i.ready = pipe_en;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    hcc_round_cell #(
      .STEP (c % 4),
      .DIAG (((c / 4) % 2) == 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (pipe_en),
      .valid_i (chain_v[c]),
      .state_i (chain_st[c]),
      .valid_o (chain_v[c+1]),
      .state_o (chain_st[c+1])
    );
  end

  // Take words 0..3 and 12..15 straight from the final matrix, no feed-forward.
  assign result.subkey_q0 = {chain_st[NUM_CELLS][1],  chain_st[NUM_CELLS][0]};
  assign result.subkey_q1 = {chain_st[NUM_CELLS][3],  chain_st[NUM_CELLS][2]};
  assign result.subkey_q2 = {chain_st[NUM_CELLS][13], chain_st[NUM_CELLS][12]};
  assign result.subkey_q3 = {chain_st[NUM_CELLS][15], chain_st[NUM_CELLS][14]};

  // Output register plus skid slot; its ready is the chain advance enable.
  hcc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_v[NUM_CELLS]),
    .data_i  (result),
    .ready_o (pipe_en),
    .valid_o (subkey_o.valid),
    .ready_i (subkey_o.ready),
    .data_o  (buf_data)
  );

  assign subkey_o.subkey_q0 = buf_data.subkey_q0;
  assign subkey_o.subkey_q1 = buf_data.subkey_q1;
  assign subkey_o.subkey_q2 = buf_data.subkey_q2;
  assign subkey_o.subkey_q3 = buf_data.subkey_q3;

  // An accepted beat must occupy the first cell on the next cycle.
  a_accept_enters_chain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_i.valid && key_i.ready) |=> chain_v[1])
    else $error("accepted beat did not enter the first cell");

  // A finished beat leaving the chain must land in the output buffer.
  a_tail_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pipe_en && chain_v[NUM_CELLS]) |=> subkey_o.valid)
    else $error("finished beat lost at the output buffer");

  // While stalled the chain must hold every cell slot and the tail data;
  // the input valid may still rise since nothing is taken.
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> ($stable(chain_v[NUM_CELLS:1]) && $stable(chain_st[NUM_CELLS])))
    else $error("chain moved while stalled");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking regression bench for the HChaCha20 subkey derivation core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hcc_pkg::*;

  localparam int unsigned DR              = HCC_DOUBLE_ROUNDS;
  // One registered step cell per quarter-round step, plus the output slot.
  localparam int unsigned LATENCY         = 8 * DR + 1;
  localparam int unsigned IDLE_PCT        = 32;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Longest legal quiet spell is the receiver hold-off plus one pass
  // through the chain; allow several times that.
  localparam int unsigned STALL_LIMIT     = 2000;

  // One key/nonce beat, lanes as they appear on the input channel.
  typedef struct packed {
    logic [63:0] key_lo0;
    logic [63:0] key_lo1;
    logic [63:0] key_hi0;
    logic [63:0] key_hi1;
    logic [63:0] nonce_lo;
    logic [63:0] nonce_hi;
  } key_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;

  // Traffic shaping knobs, flipped by the test tasks.
  bit          tx_idle_en  = 1'b0;
  bit          rx_idle_en  = 1'b0;
  bit          rx_hold_req = 1'b0;

  // Subkeys predicted for accepted key beats, oldest first.
  subkey_t     pending_subkeys[$];
  int unsigned err_count = 0;

  hcc_key_if    key_if ();
  hcc_subkey_if subkey_if ();

  hchacha20_subkey_derive #(
    .DOUBLE_ROUNDS (DR)
  ) u_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .key_i    (key_if),
    .subkey_o (subkey_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Subkey predictor
  // ---------------------------------------------------------------------------

  function automatic word_t rotl32(input word_t v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Build the 4x4 word matrix, run the double rounds, and keep rows 0 and 3.
  function automatic subkey_t derive_subkey(input key_beat_t kb);
    word_t       w [16];
    subkey_t     sk;
    int unsigned a, b, c, d, sh;
    for (int i = 0; i < 4; i++) begin
      w[i] = HCC_SIGMA[i];
    end
    {w[5],  w[4]}  = kb.key_lo0;
    {w[7],  w[6]}  = kb.key_lo1;
    {w[9],  w[8]}  = kb.key_hi0;
    {w[11], w[10]} = kb.key_hi1;
    {w[13], w[12]} = kb.nonce_lo;
    {w[15], w[14]} = kb.nonce_hi;
    for (int r = 0; r < DR; r++) begin
      // Pass 0 works on columns; pass 1 on diagonals, row k shifted by k.
      for (int pass = 0; pass < 2; pass++) begin
        sh = pass;
        for (int q = 0; q < 4; q++) begin
          a = q;
          b = 4  + (q + sh) % 4;
          c = 8  + (q + 2 * sh) % 4;
          d = 12 + (q + 3 * sh) % 4;
          w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 16);
          w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 12);
          w[a] = w[a] + w[b]; w[d] = rotl32(w[d] ^ w[a], 8);
          w[c] = w[c] + w[d]; w[b] = rotl32(w[b] ^ w[c], 7);
        end
      end
    end
    // No feed-forward: the subkey is the raw final matrix.
    sk.subkey_q0 = {w[1],  w[0]};
    sk.subkey_q1 = {w[3],  w[2]};
    sk.subkey_q2 = {w[13], w[12]};
    sk.subkey_q3 = {w[15], w[14]};
    return sk;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Bias toward all-zero, all-one, single-bit-set and single-bit-clear lanes; the rest is noise.
  function automatic logic [63:0] rand_lane();
    logic [63:0] onehot;
    onehot = 64'd1 << $urandom_range(63);
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return onehot;
      3:       return ~onehot;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic key_beat_t rand_beat();
    key_beat_t kb;
    kb.key_lo0  = rand_lane();
    kb.key_lo1  = rand_lane();
    kb.key_hi0  = rand_lane();
    kb.key_hi1  = rand_lane();
    kb.nonce_lo = rand_lane();
    kb.nonce_hi = rand_lane();
    return kb;
  endfunction

  task automatic drive_lanes(input key_beat_t kb);
    key_if.key_lo0  <= kb.key_lo0;
    key_if.key_lo1  <= kb.key_lo1;
    key_if.key_hi0  <= kb.key_hi0;
    key_if.key_hi1  <= kb.key_hi1;
    key_if.nonce_lo <= kb.nonce_lo;
    key_if.nonce_hi <= kb.nonce_hi;
  endtask

  // Offer one key beat and return at the edge that takes it. Valid is left
  // high so back-to-back beats see no bubble; idle cycles carry junk lanes.
  task automatic send_key(input key_beat_t kb);
    @(negedge clk_i);
    while (tx_idle_en && $urandom_range(99) < IDLE_PCT) begin
      key_if.valid <= 1'b0;
      drive_lanes(rand_beat());
      @(negedge clk_i);
    end
    key_if.valid <= 1'b1;
    drive_lanes(kb);
    @(posedge clk_i);
    while (!key_if.ready) @(posedge clk_i);
  endtask

  // Drop valid and hold until every predicted subkey has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    key_if.valid <= 1'b0;
    while (pending_subkeys.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_error(input string msg);
    err_count++;
    $display("[%0t] ERROR %s", $realtime, msg);
  endtask

  task automatic check_lane(input string lane, input logic [63:0] got,
                            input logic [63:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %h expected %h", lane, got, want));
    end
  endtask

  // Predict on every accepted key beat; match every accepted subkey beat
  // against the oldest prediction. Latency keeps the two from colliding.
  always @(posedge clk_i) begin : scoreboard
    key_beat_t kb;
    subkey_t   want;
    if (rst_ni) begin
      if (key_if.valid && key_if.ready) begin
        kb.key_lo0  = key_if.key_lo0;
        kb.key_lo1  = key_if.key_lo1;
        kb.key_hi0  = key_if.key_hi0;
        kb.key_hi1  = key_if.key_hi1;
        kb.nonce_lo = key_if.nonce_lo;
        kb.nonce_hi = key_if.nonce_hi;
        pending_subkeys.push_back(derive_subkey(kb));
      end
      if (subkey_if.valid && subkey_if.ready) begin
        if (pending_subkeys.size() == 0) begin
          report_error("subkey beat with no derivation pending");
        end else begin
          want = pending_subkeys.pop_front();
          check_lane("subkey_q0", subkey_if.subkey_q0, want.subkey_q0);
          check_lane("subkey_q1", subkey_if.subkey_q1, want.subkey_q1);
          check_lane("subkey_q2", subkey_if.subkey_q2, want.subkey_q2);
          check_lane("subkey_q3", subkey_if.subkey_q3, want.subkey_q3);
        end
      end
    end
  end

  // Receiver: random stalls, full rate, or a long hold-off on request.
  // The hold-off is counted here so the sender keeps pushing meanwhile.
  initial begin : rx_driver
    int unsigned hold_left;
    hold_left = 0;
    subkey_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        subkey_if.ready <= 1'b0;
        hold_left--;
      end else if (rx_idle_en) begin
        subkey_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end else begin
        subkey_if.ready <= 1'b1;
      end
    end
  end

  // Fail the run if no beat moves on either channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((key_if.valid && key_if.ready) || (subkey_if.valid && subkey_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[%0t] ERROR no beat accepted for %0d cycles", $realtime, STALL_LIMIT);
    $display("hchacha20_subkey_derive regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Lane extremes, one hot lane at a time, alternating-bit and word-boundary patterns and the
  // published HChaCha20 key/nonce, all at full rate.
  task automatic test_directed();
    key_beat_t kb;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_key('0);
    send_key('1);
    for (int i = 0; i < 6; i++) begin
      kb = '0;
      kb[64*i +: 64] = '1;
      send_key(kb);
    end
    send_key({6{64'haaaa_aaaa_aaaa_aaaa}});
    send_key({6{64'h5555_5555_5555_5555}});
    // Carry into and out of each 32-bit word.
    send_key({6{64'h8000_0000_8000_0000}});
    send_key({6{64'h7fff_ffff_7fff_ffff}});
    kb.key_lo0  = 64'h0706_0504_0302_0100;
    kb.key_lo1  = 64'h0f0e_0d0c_0b0a_0908;
    kb.key_hi0  = 64'h1716_1514_1312_1110;
    kb.key_hi1  = 64'h1f1e_1d1c_1b1a_1918;
    kb.nonce_lo = 64'h4a00_0000_0900_0000;
    kb.nonce_hi = 64'h2759_4131_0000_0000;
    send_key(kb);
    wait_drained();
  endtask

  // Random lanes with both sides stalling at random.
  task automatic test_random_traffic(input int unsigned n);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (n) send_key(rand_beat());
  endtask

  // Long stretch with no idling on either side.
  task automatic test_full_rate(input int unsigned n);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (n) send_key(rand_beat());
  endtask

  // Hold the receiver off while the sender keeps offering: the chain fills,
  // input ready drops, then everything must drain in order.
  task automatic test_output_hold_off();
    tx_idle_en  = 1'b0;
    rx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    repeat (200) send_key(rand_beat());
    rx_idle_en = 1'b1;
    repeat (40) send_key(rand_beat());
  endtask

  // Short bursts, each followed by a full drain of the chain.
  task automatic test_burst_drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (8) begin
      repeat ($urandom_range(1, 40)) send_key(rand_beat());
      wait_drained();
    end
  endtask

  initial begin : main
    key_if.valid = 1'b0;
    key_if.key_lo0  = '0;
    key_if.key_lo1  = '0;
    key_if.key_hi0  = '0;
    key_if.key_hi1  = '0;
    key_if.nonce_lo = '0;
    key_if.nonce_hi = '0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_traffic(1000);
    test_full_rate(250);
    test_output_hold_off();
    test_burst_drain();
    test_random_traffic(400);

    wait_drained();
    // Let any stray beat surface before the verdict.
    repeat (LATENCY + 20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("hchacha20_subkey_derive regression: pass");
    end else begin
      $display("hchacha20_subkey_derive regression: fail");
    end
    $finish;
  end

endmodule
